### hdl/mqalu_pkg.sv
// Shared types and constants for the modulo-3329 arithmetic pipeline.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package mqalu_pkg;

    typedef enum logic [2:0] {
        OP_CANON     = 3'd0,
        OP_IS_CANON  = 3'd1,
        OP_BARRETT   = 3'd2,
        OP_MONT_RED  = 3'd3,
        OP_TO_MONT   = 3'd4,
        OP_FROM_MONT = 3'd5,
        OP_MONT_MUL  = 3'd6
    } mqalu_op_t;

    // Field modulus and its derived constants.
    localparam logic [11:0] Q          = 12'd3329;
    localparam logic [12:0] Q_S        = 13'sd3329;
    localparam logic [15:0] QINV16     = 16'hF301;     // -3327 modulo 2^16
    localparam logic [15:0] R2_MOD_Q   = 16'sd1353;    // 2^32 mod q
    localparam logic [15:0] BARRETT_V  = 16'sd20159;
    localparam int          BARRETT_SH = 26;
    localparam logic [31:0] BARRETT_RND = 32'(64'd1 << (BARRETT_SH - 1));

    // Reciprocal for the canonical reduction: floor(2^32 / q).
    localparam logic [20:0] CANON_M    = 21'((64'd1 << 32) / 64'd3329);
    // 2^31 mod q, removed again after the offset that makes the input unsigned.
    localparam logic [11:0] CANON_BIAS = 12'((64'd1 << 31) % 64'd3329);

    typedef struct packed {
        logic ld_quot;   // load the quotient estimate stage
        logic ld_rem;    // load the remainder stage
    } mqalu_ctl_t;

endpackage

`default_nettype wire

### hdl/mqalu_canon.sv
// Two-stage reduction of a signed 32-bit value to 0..3328 by reciprocal multiply.
// Depends on mqalu_pkg for the modulus constants and the stage load struct.
`default_nettype none

module mqalu_canon
    import mqalu_pkg::*;
(
    input  wire logic        aclk,
    input  wire mqalu_ctl_t  ctl,
    input  wire logic [31:0] value_in,
    output logic      [11:0] canon_out
);

    logic [31:0] u_biased;
    logic [52:0] quot_prod;
    logic [20:0] quot_reg;
    logic [12:0] ulo_reg;
    logic [32:0] qq_prod;
    logic [12:0] rem_raw;
    logic [11:0] rem_next;
    logic [11:0] rem_reg;
    logic [12:0] unbias_sum;

    // Offsetting by 2^31 makes the value unsigned; the estimate may be one low.
    assign u_biased  = value_in ^ 32'h8000_0000;
    assign quot_prod = 53'(u_biased) * 53'(CANON_M);

    always_ff @(posedge aclk) begin
        if (ctl.ld_quot) begin
            quot_reg <= quot_prod[52:32];
            ulo_reg  <= u_biased[12:0];
        end
    end

    // The true remainder is below 2q, so 13 low bits carry it exactly.
    assign qq_prod  = 33'(quot_reg) * 33'(Q);
    assign rem_raw  = ulo_reg - qq_prod[12:0];
    assign rem_next = (rem_raw >= 13'(Q)) ? 12'(rem_raw - 13'(Q)) : rem_raw[11:0];

    always_ff @(posedge aclk) begin
        if (ctl.ld_rem) begin
            rem_reg <= rem_next;
        end
    end

    assign unbias_sum = (rem_reg >= CANON_BIAS) ? 13'(rem_reg - CANON_BIAS)
                                                : 13'(rem_reg) + 13'(Q - CANON_BIAS);
    assign canon_out  = unbias_sum[11:0];

endmodule

`default_nettype wire

### hdl/mlkem_modq_alu_core.sv
// ML-KEM modulo-3329 arithmetic unit: Barrett, Montgomery and canonical reduction.
// Throughput: one item per cycle when the output is not stalled; six pipeline registers, each with its own valid bit.
// A stage moves whenever it is empty or the stage after it moves, so bubbles close up.
// Reset (aresetn low at a clock edge) clears all valid bits; payload registers are not reset.
// Depends on mqalu_pkg and mqalu_canon.
`default_nettype none

module mlkem_modq_alu_core
    import mqalu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [31:0] operand_a, [47:32] operand_b
    input  wire logic [2:0]  s_tuser,   // [2:0] opcode
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] result_value
    output logic      [0:0]  m_tuser    // [0] canonical_flag
);

    // Valid bits and ready chain. Stage k loads when it is empty or stage k+1 loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic ld1, ld2, ld3, ld4, ld5, ld6;

    assign rdy6 = !v6_reg || m_tready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ld1 = rdy1 && s_tvalid;
    assign ld2 = rdy2 && v1_reg;
    assign ld3 = rdy3 && v2_reg;
    assign ld4 = rdy4 && v3_reg;
    assign ld5 = rdy5 && v4_reg;
    assign ld6 = rdy6 && v5_reg;

    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: operand products. The Montgomery path input is either operand_a
    // itself, its signed low half, or that half times operand_b or times 2^32 mod q.
    // The inner canonicalization of the conversion into Montgomery form is dropped:
    // every later step is exact, and the final reduction sees only the residue.
    mqalu_op_t          in_op;
    logic signed [15:0] in_a16;
    logic signed [15:0] in_b16;
    logic signed [15:0] mul_rhs;
    logic signed [31:0] mul_prod;
    logic signed [31:0] bar_prod;
    logic        [31:0] mont_in_next;
    logic               flag_next;

    assign in_op    = mqalu_op_t'(s_tuser[2:0]);
    assign in_a16   = s_tdata[15:0];
    assign in_b16   = s_tdata[47:32];
    assign mul_rhs  = (in_op == OP_MONT_MUL) ? in_b16 : R2_MOD_Q;
    assign mul_prod = in_a16 * mul_rhs;
    assign bar_prod = in_a16 * $signed(BARRETT_V);
    assign flag_next = (in_op == OP_IS_CANON) && !in_a16[15] && (in_a16 < $signed(16'(Q)));

    always_comb begin
        case (in_op) inside
            OP_CANON, OP_MONT_RED: mont_in_next = s_tdata[31:0];
            OP_FROM_MONT:          mont_in_next = 32'(in_a16);
            default:               mont_in_next = mul_prod;
        endcase
    end

    mqalu_op_t   op1_reg;
    logic [31:0] a1_reg;
    logic [31:0] mont_in1_reg;
    logic [31:0] bar_prod1_reg;
    logic        flag1_reg;

    always_ff @(posedge aclk) begin
        if (ld1) begin
            op1_reg       <= in_op;
            a1_reg        <= s_tdata[31:0];
            mont_in1_reg  <= mont_in_next;
            bar_prod1_reg <= bar_prod;
            flag1_reg     <= flag_next;
        end
    end

    // Stage 2: Montgomery factor t = low half of (input * qinv), and the rounded
    // Barrett quotient, which lies in -10..10 and fits six signed bits.
    logic [31:0] tm_prod;
    logic [31:0] bar_rnd;

    assign tm_prod = 32'(mont_in1_reg[15:0]) * 32'(QINV16);
    assign bar_rnd = bar_prod1_reg + BARRETT_RND;

    mqalu_op_t   op2_reg;
    logic [31:0] a2_reg;
    logic [31:0] mont_in2_reg;
    logic [15:0] tm2_reg;
    logic [5:0]  tb2_reg;
    logic        flag2_reg;

    always_ff @(posedge aclk) begin
        if (ld2) begin
            op2_reg      <= op1_reg;
            a2_reg       <= a1_reg;
            mont_in2_reg <= mont_in1_reg;
            tm2_reg      <= tm_prod[15:0];
            tb2_reg      <= bar_rnd[31:26];
            flag2_reg    <= flag1_reg;
        end
    end

    // Stage 3: subtract t*q. The low half of the Montgomery difference is zero,
    // so the high half is the reduced value; the Barrett result wraps to 16 bits.
    logic signed [28:0] tq_prod;
    logic        [31:0] mont_diff;
    logic signed [18:0] tbq_prod;
    logic        [15:0] bar_res;

    assign tq_prod   = $signed(tm2_reg) * $signed(Q_S);
    assign mont_diff = mont_in2_reg - 32'(tq_prod);
    assign tbq_prod  = $signed(tb2_reg) * $signed(Q_S);
    assign bar_res   = a2_reg[15:0] - tbq_prod[15:0];

    mqalu_op_t   op3_reg;
    logic [31:0] a3_reg;
    logic [15:0] mont3_reg;
    logic [15:0] bar3_reg;
    logic        flag3_reg;

    always_ff @(posedge aclk) begin
        if (ld3) begin
            op3_reg   <= op2_reg;
            a3_reg    <= a2_reg;
            mont3_reg <= mont_diff[31:16];
            bar3_reg  <= bar_res;
            flag3_reg <= flag2_reg;
        end
    end

    // Stages 4 and 5: canonical reduction of either operand_a or the Montgomery result.
    logic [31:0] canon_in;
    logic [11:0] canon_val;
    mqalu_ctl_t  canon_ctl;

    assign canon_in = (op3_reg == OP_CANON) ? a3_reg : {{16{mont3_reg[15]}}, mont3_reg};
    assign canon_ctl.ld_quot = ld4;
    assign canon_ctl.ld_rem  = ld5;

    mqalu_canon u_canon (
        .aclk      (aclk),
        .ctl       (canon_ctl),
        .value_in  (canon_in),
        .canon_out (canon_val)
    );

    mqalu_op_t   op4_reg, op5_reg;
    logic [15:0] mont4_reg, mont5_reg;
    logic [15:0] bar4_reg, bar5_reg;
    logic        flag4_reg, flag5_reg;

    always_ff @(posedge aclk) begin
        if (ld4) begin
            op4_reg   <= op3_reg;
            mont4_reg <= mont3_reg;
            bar4_reg  <= bar3_reg;
            flag4_reg <= flag3_reg;
        end
        if (ld5) begin
            op5_reg   <= op4_reg;
            mont5_reg <= mont4_reg;
            bar5_reg  <= bar4_reg;
            flag5_reg <= flag4_reg;
        end
    end

    // Stage 6: result selection into the output register. The test opcode and
    // the unused code give a zero value.
    logic [15:0] result_next;

    always_comb begin
        case (op5_reg) inside
            OP_CANON, OP_TO_MONT, OP_FROM_MONT, OP_MONT_MUL:
                result_next = 16'(canon_val);
            OP_MONT_RED: result_next = mont5_reg;
            OP_BARRETT:  result_next = bar5_reg;
            default:     result_next = 16'd0;
        endcase
    end

    logic [15:0] result_reg;
    logic        flag6_reg;

    always_ff @(posedge aclk) begin
        if (ld6) begin
            result_reg <= result_next;
            flag6_reg  <= flag5_reg;
        end
    end

    assign m_tvalid   = v6_reg;
    assign m_tdata    = result_reg;
    assign m_tuser[0] = flag6_reg;

endmodule

`default_nettype wire

### hdl/mqalu_checker.sv
// Port-level checks for the modulo-3329 arithmetic pipeline, bound to its top level.
// Depends on mqalu_pkg for the opcode names and on the top level's port list.
`default_nettype none

module mqalu_checker
    import mqalu_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A held result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Only the test opcode raises the flag, and it always carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("flagged result with nonzero value");

    // An in-range test item comes out flagged on a free-running output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_IS_CANON && !s_tdata[15]
            && s_tdata[15:0] < 16'd3329
            ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && m_tuser[0])
        else $error("canonical test result missing or unflagged");

endmodule

bind mlkem_modq_alu_core mqalu_checker u_mqalu_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for mlkem_modq_alu_core: directed and random transfers through both streams.
// Each accepted input is predicted by a scoreboard class and compared with the result stream.
// Depends on mqalu_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_top;
    import mqalu_pkg::*;

    // Opcode 7 has no member in the package enum; the core must answer it with zeros.
    localparam logic [2:0] OP_RESERVED = 3'd7;

    // Number of consecutive cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;

    // Cycles to keep watching the result side after the last expected result.
    localparam int DRAIN_CYCLES = 12;

    // Items per random phase.
    localparam int PHASE_ITEMS = 440;

    // The scoreboard keeps one expected result per accepted input, oldest first.
    class modq_scoreboard;
        localparam int               MODULUS       = 3329;
        localparam int               MONT_R2       = 1353;
        localparam longint           BARRETT_MULT  = 20159;
        localparam int               BARRETT_SHIFT = 26;
        localparam logic [31:0]      MONT_QINV     = 32'hFFFF_F301;

        typedef struct packed {
            logic [15:0] value;
            logic        flag;
        } modq_result_t;

        modq_result_t pending_results[$];
        int           errors;
        int           results_seen;

        function new();
            errors       = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Remainder in 0..q-1, whatever the sign of the input.
        function int canon_q(longint v);
            longint r;
            r = v % MODULUS;
            if (r < 0) begin
                r += MODULUS;
            end
            return int'(r);
        endfunction

        // Montgomery reduction with R = 2^16; the subtraction wraps at 32 bits.
        function logic signed [15:0] mont_reduce(logic [31:0] a);
            logic [31:0] prod;
            logic [15:0] t;
            logic [31:0] diff;
            prod = a * MONT_QINV;
            t    = prod[15:0];
            diff = a - {{16{t[15]}}, t} * 32'd3329;
            return diff[31:16];
        endfunction

        // Work out the result of one accepted input and queue it.
        function void note_input(logic [2:0] op, logic [31:0] a, logic [15:0] b);
            longint       a32;
            longint       a16;
            longint       b16;
            longint       prod;
            longint       quot;
            modq_result_t want;
            a32  = longint'($signed(a));
            a16  = longint'($signed(a[15:0]));
            b16  = longint'($signed(b));
            want = '0;
            case (op)
                OP_CANON: begin
                    want.value = 16'(canon_q(a32));
                end
                OP_IS_CANON: begin
                    want.flag = (a16 >= 0 && a16 < MODULUS);
                end
                OP_BARRETT: begin
                    // Arithmetic shift of a signed 64-bit value is the floor division.
                    prod       = BARRETT_MULT * a16 + (longint'(1) << (BARRETT_SHIFT - 1));
                    quot       = prod >>> BARRETT_SHIFT;
                    want.value = 16'(a16 - quot * MODULUS);
                end
                OP_MONT_RED: begin
                    want.value = mont_reduce(a);
                end
                OP_TO_MONT: begin
                    want.value = 16'(canon_q(mont_reduce(32'(canon_q(a16) * MONT_R2))));
                end
                OP_FROM_MONT: begin
                    want.value = 16'(canon_q(mont_reduce(32'(a16))));
                end
                OP_MONT_MUL: begin
                    want.value = 16'(canon_q(mont_reduce(32'(a16 * b16))));
                end
                default: begin
                end
            endcase
            pending_results.push_back(want);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [15:0] value, logic flag);
            modq_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result value=%h flag=%b with nothing expected", value, flag));
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value) begin
                report($sformatf("result %0d: value %h, expected %h",
                                 results_seen, value, want.value));
            end
            if (flag !== want.flag) begin
                report($sformatf("result %0d: canonical flag %b, expected %b",
                                 results_seen, flag, want.flag));
            end
            results_seen++;
        endtask
    endclass

    // Receiver behavior: always ready, chopped by random patterns, or mostly stalled.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_STARVED
    } rx_mode_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [31:0] operand_a, [47:32] operand_b
    logic [2:0]  s_tuser  = '0;   // [2:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] result_value
    logic [0:0]  m_tuser;         // [0] canonical_flag

    modq_scoreboard sb;

    rx_mode_t    rx_mode       = RX_OPEN;
    logic [15:0] rx_pat        = '1;
    int          rx_pos        = 0;
    int          tx_gap_max    = 0;
    int          tx_burst_left = 0;
    int          quiet_cycles  = 0;

    mlkem_modq_alu_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // The receiver replays a 16-bit ready pattern and picks a fresh one each time it wraps.
    // A starved pattern always keeps one ready bit so the longest stall stays bounded.
    always @(negedge aclk) begin
        if (rx_pos == 0) begin
            case (rx_mode)
                RX_OPEN: begin
                    rx_pat = '1;
                end
                RX_CHOPPY: begin
                    rx_pat = ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0001);
                end
                default: begin
                    rx_pat = 16'($urandom & $urandom & $urandom) | 16'h0100;
                end
            endcase
        end
        m_tready <= rx_pat[rx_pos];
        rx_pos = (rx_pos + 1) % 16;
    end

    // Both channels are sampled at the rising edge, before the core's registers update.
    // An input transfer is predicted immediately; a result transfer is checked against the
    // oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata[31:0], s_tdata[47:32]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser[0]);
            end
        end
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** mlkem_modq_alu_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item and returns at the falling edge after its transfer. The sender works
    // in bursts; when a burst is used up, valid drops for a random number of cycles.
    // With tx_gap_max at zero the sender never idles. Called at a falling edge.
    task drive_item(logic [2:0] op, logic [31:0] a, logic [15:0] b);
        if (tx_gap_max > 0) begin
            if (tx_burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(negedge aclk);
                tx_burst_left = $urandom_range(1, 24);
            end
            tx_burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Operand A mixes full-range words, small signed values, the canonical range with
    // random upper halves (the 16-bit opcodes must ignore them), and the 16-bit and
    // 32-bit extremes.
    function logic [31:0] pick_operand_a();
        logic [15:0] upper;
        upper = 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return 32'(int'($urandom_range(0, 13316)) - 6658);
            3:       return {upper, 16'($urandom_range(0, 3329))};
            4:       return {upper, ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000};
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    function logic [15:0] pick_operand_b();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom);
            2:       return 16'(int'($urandom_range(0, 6658)) - 3329);
            default: return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    initial begin
        sb = new();

        // Synchronous reset, released at a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: field extremes, every opcode, the unused opcode, canonical-test
        // boundaries, and Montgomery reduction of operands that need the wrapped difference.
        tx_gap_max = 3;
        rx_mode    = RX_CHOPPY;
        drive_item(OP_CANON,     32'h0000_0000, 16'h0000);
        drive_item(OP_CANON,     32'hFFFF_FFFF, 16'hFFFF);
        drive_item(OP_CANON,     32'h7FFF_FFFF, 16'h0000);
        drive_item(OP_CANON,     32'h8000_0000, 16'h0000);
        drive_item(OP_CANON,     32'd3329,      16'h0000);
        drive_item(OP_IS_CANON,  32'hABCD_0D00, 16'h0000);
        drive_item(OP_IS_CANON,  32'h0000_0D01, 16'h0000);
        drive_item(OP_IS_CANON,  32'h0000_FFFF, 16'h0000);
        drive_item(OP_IS_CANON,  32'hFFFF_0000, 16'h0000);
        drive_item(OP_BARRETT,   32'h0000_7FFF, 16'h0000);
        drive_item(OP_BARRETT,   32'h1234_8000, 16'h0000);
        drive_item(OP_BARRETT,   32'h0000_0D01, 16'h0000);
        drive_item(OP_MONT_RED,  32'h7FFF_FFFF, 16'h0000);
        drive_item(OP_MONT_RED,  32'h8000_0000, 16'h0000);
        drive_item(OP_MONT_RED,  32'hFFFF_FFFF, 16'h0000);
        drive_item(OP_TO_MONT,   32'h0000_8000, 16'h0000);
        drive_item(OP_TO_MONT,   32'hFFFF_7FFF, 16'h0000);
        drive_item(OP_FROM_MONT, 32'h0000_7FFF, 16'h0000);
        drive_item(OP_FROM_MONT, 32'h5A5A_8000, 16'h0000);
        drive_item(OP_MONT_MUL,  32'h0000_8000, 16'h8000);
        drive_item(OP_MONT_MUL,  32'hFFFF_7FFF, 16'h8000);
        drive_item(OP_MONT_MUL,  32'h0000_7FFF, 16'h7FFF);
        drive_item(OP_RESERVED,  32'hDEAD_BEEF, 16'hFFFF);
        drive_item(OP_RESERVED,  32'h0000_0000, 16'h0000);

        // Random part in four phases that vary how often each side idles, so bubbles and
        // stalls land on every pipeline stage, including a phase that streams at full rate.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_gap_max = 0;
                    rx_mode    = RX_OPEN;
                end
                1: begin
                    tx_gap_max = 4;
                    rx_mode    = RX_CHOPPY;
                end
                2: begin
                    tx_gap_max = 2;
                    rx_mode    = RX_STARVED;
                end
                default: begin
                    tx_gap_max = 8;
                    rx_mode    = RX_CHOPPY;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                drive_item(3'($urandom_range(0, 7)), pick_operand_a(), pick_operand_b());
            end
        end
        s_tvalid <= 1'b0;

        // Wait for every predicted result, then keep watching for stray transfers.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("** mlkem_modq_alu_core: PASSED **");
        end else begin
            $display("** mlkem_modq_alu_core: FAILED **");
        end
        $finish;
    end

endmodule
